FILE: src/tts_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the power-of-two table for the tanh tube waveshaper.
// No dependencies; every other file imports this package.
package tts_pkg;

    // Port widths
    localparam int SAMPLE_W    = 16;
    localparam int OUT_W       = 17;
    localparam int CFG_W       = 16;
    localparam int CFG_ADDR_W  = 2;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 40;

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_DRIVE_GAIN = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BUMP_DEPTH = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BUMP_WIDTH = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] DRIVE_GAIN_RST = 16'd4096;
    localparam logic [CFG_W-1:0] BUMP_DEPTH_RST = 16'd3277;
    localparam logic [CFG_W-1:0] BUMP_WIDTH_RST = 16'd51200;

    // Fixed-point constants
    localparam logic [16:0] LOG2E_Q16     = 17'd94548;
    localparam logic [17:0] TWO_LOG2E_Q16 = 18'd189096;
    localparam logic [31:0] ONE_Q30       = 32'd1073741824;
    localparam logic [31:0] HALF_Q30      = 32'd536870912;

    // Default geometry of the pipelined dividers and power-of-two units
    localparam int DIV_NW_DEF  = 46;
    localparam int DIV_DW_DEF  = 32;
    localparam int DIV_QW_DEF  = 16;
    localparam int SIDE_W_DEF  = 1;
    localparam int POW_WW_DEF  = 22;

    // 2^(-k/16) in Q1.16, k = 0..16
    function automatic logic [16:0] pow2_tab(input logic [4:0] k);
        logic [16:0] v;
        case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/tts_pow2.sv
`timescale 1ns / 1ps
// Three-stage 2^(-w) unit: table lookup, interpolation product, shift by integer part.
// Input w is Q16, result is Q30. Depends on tts_pkg.
module tts_pow2
    import tts_pkg::*;
#(
    parameter int WW = POW_WW_DEF,
    parameter int SW = SIDE_W_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ce,
    input  logic          i_vld,
    input  logic [WW-1:0] i_w,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [30:0]   o_e,
    output logic [SW-1:0] o_side
);

    // Stage 1 registers
    logic          r1_vld;
    logic          r1_zero;
    logic [4:0]    r1_n;
    logic [16:0]   r1_t0;
    logic [11:0]   r1_dif;
    logic [11:0]   r1_r;
    logic [SW-1:0] r1_side;
    // Stage 2 registers
    logic          r2_vld;
    logic          r2_zero;
    logic [4:0]    r2_n;
    logic [16:0]   r2_t0;
    logic [23:0]   r2_prod;
    logic [SW-1:0] r2_side;
    // Stage 3 registers
    logic          r3_vld;
    logic [30:0]   r3_e;
    logic [SW-1:0] r3_side;

    logic [WW-17:0] n_int;
    logic [4:0]     n_idx;
    logic [16:0]    n_t0;
    logic [16:0]    n_t1;
    logic [16:0]    n_m;
    logic [30:0]    n_e;

    // Split w and look up the two neighboring table entries
    always_comb begin
        n_int = i_w[WW-1:16];
        n_idx = {1'b0, i_w[15:12]};
        n_t0  = pow2_tab(n_idx);
        n_t1  = pow2_tab(n_idx + 5'd1);
    end

    // Interpolate and scale down by the integer part
    always_comb begin
        n_m = r2_t0 - {5'd0, r2_prod[23:12]};
        n_e = r2_zero ? 31'd0 : ({n_m, 14'd0} >> r2_n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_ce) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
        if (i_ce) begin
            r1_zero <= (n_int >= (WW-16)'(31));
            r1_n    <= n_int[4:0];
            r1_t0   <= n_t0;
            r1_dif  <= 12'(n_t0 - n_t1);
            r1_r    <= i_w[11:0];
            r1_side <= i_side;
            r2_zero <= r1_zero;
            r2_n    <= r1_n;
            r2_t0   <= r1_t0;
            r2_prod <= r1_dif * r1_r;
            r2_side <= r1_side;
            r3_e    <= n_e;
            r3_side <= r2_side;
        end
    end

    assign o_vld  = r3_vld;
    assign o_e    = r3_e;
    assign o_side = r3_side;

endmodule

FILE: src/tts_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per register stage, with side payload.
// The quotient must fit in QW bits. Depends on tts_pkg.
module tts_div
    import tts_pkg::*;
#(
    parameter int NW = DIV_NW_DEF,
    parameter int DW = DIV_DW_DEF,
    parameter int QW = DIV_QW_DEF,
    parameter int SW = SIDE_W_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ce,
    input  logic          i_vld,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [QW-1:0] o_quot,
    output logic [SW-1:0] o_side
);

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic          vld_in;
        logic [DW-1:0] rem_in;
        logic [DW-1:0] div_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] q_in;
        logic [SW-1:0] side_in;
        logic [DW:0]   part;
        logic [DW:0]   dif;
        logic [DW-1:0] n_rem;
        logic          n_qbit;
        // Stage registers
        logic          r_vld;
        logic [DW-1:0] r_rem;
        logic [DW-1:0] r_div;
        logic [QW-1:0] r_low;
        logic [QW-1:0] r_q;
        logic [SW-1:0] r_side;

        if (k == 0) begin : g_first
            assign vld_in  = i_vld;
            assign rem_in  = DW'(i_dividend >> QW);
            assign div_in  = i_divisor;
            assign low_in  = i_dividend[QW-1:0];
            assign q_in    = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = g_step[k-1].r_vld;
            assign rem_in  = g_step[k-1].r_rem;
            assign div_in  = g_step[k-1].r_div;
            assign low_in  = g_step[k-1].r_low;
            assign q_in    = g_step[k-1].r_q;
            assign side_in = g_step[k-1].r_side;
        end

        // Bring down one dividend bit, subtract where the divisor fits
        always_comb begin
            part = {rem_in, low_in[QW-1]};
            dif  = part - {1'b0, div_in};
            if (!dif[DW]) begin
                n_rem  = dif[DW-1:0];
                n_qbit = 1'b1;
            end else begin
                n_rem  = part[DW-1:0];
                n_qbit = 1'b0;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_ce) begin
                r_vld <= vld_in;
            end
            if (i_ce) begin
                r_rem  <= n_rem;
                r_div  <= div_in;
                r_low  <= {low_in[QW-2:0], 1'b0};
                r_q    <= {q_in[QW-2:0], n_qbit};
                r_side <= side_in;
            end
        end
    end

    assign o_vld  = g_step[QW-1].r_vld;
    assign o_quot = g_step[QW-1].r_q;
    assign o_side = g_step[QW-1].r_side;

endmodule

FILE: src/tts_chan.sv
`timescale 1ns / 1ps
// One channel of the waveshaper: gain, tanh via 2^x and a divider, exp bump, saturation.
// Depends on tts_pkg, tts_pow2 and tts_div.
module tts_chan
    import tts_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_ce,
    input  logic                       i_vld,
    input  logic signed [SAMPLE_W-1:0] i_x,
    input  logic [CFG_W-1:0]           i_drive_gain,
    input  logic [CFG_W-1:0]           i_bump_depth,
    input  logic [CFG_W-1:0]           i_bump_width,
    output logic                       o_vld,
    output logic signed [OUT_W-1:0]    o_y
);

    // Magnitude, gain, exponent stages
    logic        r1_vld, r1_neg;
    logic [16:0] r1_mag;
    logic        r2_vld, r2_neg;
    logic [19:0] r2_a;
    logic        r3_vld, r3_neg;
    logic [21:0] r3_w;
    // tanh divider operands
    logic        p1_vld;
    logic [30:0] p1_e;
    logic        p1_neg;
    logic        r4_vld, r4_neg;
    logic [45:0] r4_num;
    logic [31:0] r4_den;
    // tanh result and bump exponent
    logic        d1_vld;
    logic [15:0] d1_y;
    logic        d1_neg;
    logic        r5_vld, r5_neg;
    logic [15:0] r5_y;
    logic [30:0] r5_sq;
    logic        r6_vld, r6_neg;
    logic [15:0] r6_y;
    logic [22:0] r6_p;
    logic        d2_vld;
    logic [22:0] d2_q;
    logic [16:0] d2_side;
    logic        p2_vld;
    logic [30:0] p2_b;
    logic [16:0] p2_side;
    // Bump factor, product, saturation
    logic        r7_vld, r7_neg;
    logic [15:0] r7_y;
    logic [32:0] r7_fac;
    logic        r8_vld, r8_neg;
    logic [48:0] r8_pr;
    logic        r9_vld;
    logic [16:0] r9_y;

    logic [16:0] n_xs;
    logic [16:0] n_mag;
    logic [32:0] n_ga;
    logic [37:0] n_wp;
    logic [31:0] n_den;
    logic [45:0] n_num;
    logic [47:0] n_pp;
    logic [22:0] n_w2;
    logic [46:0] n_bt;
    logic [48:0] n_sum;
    logic [18:0] n_m;
    logic [16:0] n_y;

    always_comb begin
        n_xs  = {i_x[SAMPLE_W-1], i_x};
        n_mag = i_x[SAMPLE_W-1] ? (~n_xs + 17'd1) : n_xs;
        n_ga  = r1_mag * i_drive_gain;
        n_wp  = r2_a * TWO_LOG2E_Q16;
        n_den = ONE_Q30 + {1'b0, p1_e};
        n_num = {(ONE_Q30[30:0] - p1_e), 15'd0} + {15'd0, n_den[31:1]};
        n_pp  = r5_sq * LOG2E_Q16;
        // A zero bump width drops the bump: drive the exponent past its range
        n_w2  = (i_bump_width == '0) ? '1 : d2_q;
        n_bt  = i_bump_depth * p2_b;
        n_sum = r8_pr + {17'd0, HALF_Q30};
        n_m   = n_sum[48:30];
        if (r8_neg) begin
            n_y = (n_m > 19'd65536) ? 17'h10000 : 17'(~n_m + 19'd1);
        end else begin
            n_y = (n_m > 19'd65535) ? 17'h0FFFF : n_m[16:0];
        end
    end

    // Magnitude, gain, tanh exponent 2 * a * log2(e), and the tanh divider operands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_ce) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= p1_vld;
        end
        if (i_ce) begin
            r1_neg <= i_x[SAMPLE_W-1];
            r1_mag <= n_mag;
            r2_neg <= r1_neg;
            r2_a   <= n_ga[30:11];
            r3_neg <= r2_neg;
            r3_w   <= n_wp[37:16];
            r4_neg <= p1_neg;
            r4_den <= n_den;
            r4_num <= n_num;
        end
    end

    tts_pow2 #(
        .WW (22),
        .SW (1)
    ) u_pow_tanh (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (i_ce),
        .i_vld   (r3_vld),
        .i_w     (r3_w),
        .i_side  (r3_neg),
        .o_vld   (p1_vld),
        .o_e     (p1_e),
        .o_side  (p1_neg)
    );

    // y = round((1 - E) / (1 + E)) in Q15
    tts_div #(
        .NW (46),
        .DW (32),
        .QW (16),
        .SW (1)
    ) u_div_tanh (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ce       (i_ce),
        .i_vld      (r4_vld),
        .i_dividend (r4_num),
        .i_divisor  (r4_den),
        .i_side     (r4_neg),
        .o_vld      (d1_vld),
        .o_quot     (d1_y),
        .o_side     (d1_neg)
    );

    // Square and scale y for the bump exponent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else if (i_ce) begin
            r5_vld <= d1_vld;
            r6_vld <= r5_vld;
        end
        if (i_ce) begin
            r5_neg <= d1_neg;
            r5_y   <= d1_y;
            r5_sq  <= 31'(d1_y * d1_y);
            r6_neg <= r5_neg;
            r6_y   <= r5_y;
            r6_p   <= n_pp[46:24];
        end
    end

    tts_div #(
        .NW (23),
        .DW (16),
        .QW (23),
        .SW (17)
    ) u_div_bump (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ce       (i_ce),
        .i_vld      (r6_vld),
        .i_dividend (r6_p),
        .i_divisor  (i_bump_width),
        .i_side     ({r6_neg, r6_y}),
        .o_vld      (d2_vld),
        .o_quot     (d2_q),
        .o_side     (d2_side)
    );

    tts_pow2 #(
        .WW (23),
        .SW (17)
    ) u_pow_bump (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (i_ce),
        .i_vld   (d2_vld),
        .i_w     (n_w2),
        .i_side  (d2_side),
        .o_vld   (p2_vld),
        .o_e     (p2_b),
        .o_side  (p2_side)
    );

    // Bump factor, output product, round and saturate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
            r8_vld <= 1'b0;
            r9_vld <= 1'b0;
        end else if (i_ce) begin
            r7_vld <= p2_vld;
            r8_vld <= r7_vld;
            r9_vld <= r8_vld;
        end
        if (i_ce) begin
            r7_neg <= p2_side[16];
            r7_y   <= p2_side[15:0];
            r7_fac <= {1'b0, ONE_Q30} + {1'b0, n_bt[46:15]};
            r8_neg <= r7_neg;
            r8_pr  <= r7_y * r7_fac;
            r9_y   <= n_y;
        end
    end

    assign o_vld = r9_vld;
    assign o_y   = r9_y;

endmodule

FILE: src/tanh_tube_waveshaper.sv
`timescale 1ns / 1ps
// Stereo tanh waveshaper with exponential bump: top level with stream ports and registers.
// Depends on tts_pkg and tts_chan (which uses tts_pow2 and tts_div).
//
// Takes one stereo pair per clock and returns the shaped pair; a new request is accepted
// every cycle while the output side takes results. Each channel holds two pipelined
// restoring dividers (16 stages for tanh, 23 for the bump exponent), one quotient bit per
// stage. When the output is held, the whole pipeline freezes and the input side stalls with
// it; nothing is dropped or repeated. Registers (0 drive gain, 1 bump depth, 2 bump width;
// index 3 ignored) are taken at any write enable and are meant to change only while no
// request is in flight.
module tanh_tube_waveshaper
    import tts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,   // [15:0] left_sample, [31:16] right_sample
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,   // [16:0] left_out, [33:17] right_out, rest 0
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    logic [CFG_W-1:0] r_drive_gain;
    logic [CFG_W-1:0] r_bump_depth;
    logic [CFG_W-1:0] r_bump_width;

    logic                    ce;
    logic                    left_vld;
    logic                    right_vld;
    logic signed [OUT_W-1:0] left_out;
    logic signed [OUT_W-1:0] right_out;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_gain <= DRIVE_GAIN_RST;
            r_bump_depth <= BUMP_DEPTH_RST;
            r_bump_width <= BUMP_WIDTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_DRIVE_GAIN: r_drive_gain <= i_cfg_data;
                CFG_BUMP_DEPTH: r_bump_depth <= i_cfg_data;
                CFG_BUMP_WIDTH: r_bump_width <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the pipeline whenever the output register is free or being taken
    assign ce         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = ce;

    tts_chan u_left (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ce         (ce),
        .i_vld        (i_s_tvalid),
        .i_x          (i_s_tdata[15:0]),
        .i_drive_gain (r_drive_gain),
        .i_bump_depth (r_bump_depth),
        .i_bump_width (r_bump_width),
        .o_vld        (left_vld),
        .o_y          (left_out)
    );

    tts_chan u_right (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ce         (ce),
        .i_vld        (i_s_tvalid),
        .i_x          (i_s_tdata[31:16]),
        .i_drive_gain (r_drive_gain),
        .i_bump_depth (r_bump_depth),
        .i_bump_width (r_bump_width),
        .o_vld        (right_vld),
        .o_y          (right_out)
    );

    // Both lanes run in lockstep
    assign o_m_tvalid = left_vld && right_vld;
    assign o_m_tdata  = {6'd0, right_out, left_out};

endmodule

FILE: src/tts_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the tanh tube waveshaper, bound to the top level.
// Depends on tts_pkg and tanh_tube_waveshaper.
module tts_checker
    import tts_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_s_tready,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [M_TDATA_W-1:0]  o_m_tdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed or dropped");

    // Accept requests whenever the output register is empty
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled while output register empty");

    // Stall the input only when a result waits
    a_stall_only_on_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("input stalled without a waiting result");

    // Keep padding bits clear
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[M_TDATA_W-1:2*OUT_W] == '0)
        else $error("output padding bits not zero");

    // Clear results on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

endmodule

bind tanh_tube_waveshaper tts_checker u_tts_checker (.*);
